// File: rtl/core/idrq_pkg.sv
package idrq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW         = $clog2(DEPTH + 1);

  localparam int CMD_W    = 3;
  localparam int VAL_W    = 32;
  localparam int FILL_W   = 5;
  localparam int STATUS_W = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 72;

  typedef logic [AW-1:0]                addr_t;
  typedef logic [AW:0]                  addr_sum_t;
  typedef logic [CW-1:0]                count_t;
  typedef logic signed [DATA_WIDTH-1:0] elem_t;
  typedef logic signed [VAL_W-1:0]      val_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH      = 3'd0,
    CMD_POP_FRONT = 3'd1,
    CMD_POP_BACK  = 3'd2,
    CMD_CLEAR     = 3'd3,
    CMD_PEEK      = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef struct packed {
    count_t  count;
    status_t status;
    logic    fwd_front;
    logic    fwd_back;
    elem_t   push_elem;
  } meta_t;

  localparam addr_sum_t DEPTH_SUM = addr_sum_t'(DEPTH);

  function automatic addr_t wrap_addr(input addr_sum_t sum);
    addr_sum_t r;
    r = (sum >= DEPTH_SUM) ? sum - DEPTH_SUM : sum;
    return r[AW-1:0];
  endfunction

  function automatic elem_t to_elem(input val_t v);
    return elem_t'(v);
  endfunction

  function automatic val_t from_elem(input elem_t e);
    return val_t'(e);
  endfunction

endpackage

// File: rtl/core/input_restricted_deque_ring.sv
// Input-restricted deque held in a ring memory of DEPTH entries.
// Slave side: one transaction per command. in_tuser carries cmd
// (push back, pop front, pop back, clear, peek), in_tdata the push value.
// Master side: one transaction per command with the front and back
// elements (zero when empty), fill count, empty flag and status
// (ok, underflow on pop from empty, overflow when a push hits a full ring).
// A taken command sets rd_pending_r, and out_tvalid rises after that flag:
// pointers update and the ring memory is read in the accept cycle, the
// synchronous read data is muxed into the output register in the next.
// in_tready stays low while the memory read is pending, so a new command
// is taken only after the read data is captured; a write to a slot read in the same
// cycle is forwarded from the push value.
// Reset clears the head pointer, the count and both valid flags; ring
// contents are left as they are and never used outside the live window.
// A stalled out_tready holds the result, and in_tready stays low until
// the result is taken.
module input_restricted_deque_ring (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [idrq_pkg::IN_DATA_W-1:0]     in_tdata,   // [31:0] push_value
  input  logic [idrq_pkg::CMD_W-1:0]         in_tuser,   // [2:0] cmd
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] front_value, [63:32] back_value, [68:64] fill_count,
  // [69] is_empty, [71:70] status
  output logic [idrq_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import idrq_pkg::*;

  logic   accept;
  logic   ram_we;
  addr_t  ram_waddr;
  elem_t  ram_wdata;
  addr_t  raddr_front, raddr_back;
  elem_t  rdata_front, rdata_back;
  meta_t  meta_r;

  logic   rd_pending_r;
  logic   out_valid_r;
  val_t   front_r, front_nxt;
  val_t   back_r, back_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic                empty_r, empty_nxt;
  logic [STATUS_W-1:0] status_r;

  assign in_tready = !rd_pending_r && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  idrq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .cmd         (in_tuser),
    .push_value  (val_t'(in_tdata)),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .raddr_front (raddr_front),
    .raddr_back  (raddr_back),
    .meta_r      (meta_r)
  );

  idrq_ram u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (accept),
    .raddr_a (raddr_front),
    .raddr_b (raddr_back),
    .rdata_a (rdata_front),
    .rdata_b (rdata_back)
  );

  always_comb begin
    empty_nxt = (meta_r.count == '0);
    fill_nxt  = FILL_W'(meta_r.count);
    if (empty_nxt) begin
      front_nxt = '0;
      back_nxt  = '0;
    end else begin
      front_nxt = from_elem(meta_r.fwd_front ? meta_r.push_elem : rdata_front);
      back_nxt  = from_elem(meta_r.fwd_back  ? meta_r.push_elem : rdata_back);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pending_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      rd_pending_r <= accept;
      if (rd_pending_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pending_r) begin
      front_r  <= front_nxt;
      back_r   <= back_nxt;
      fill_r   <= fill_nxt;
      empty_r  <= empty_nxt;
      status_r <= meta_r.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {status_r, empty_r, fill_r, back_r, front_r};

  a_rd_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pending_r |-> !out_valid_r)
    else $error("read data returned while result still held");

  a_accept_rd: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> rd_pending_r)
    else $error("accepted transaction did not start a read");

  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (fill_r <= FILL_W'(DEPTH)))
    else $error("fill count above depth");

  a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (empty_r == (fill_r == '0)))
    else $error("empty flag disagrees with fill count");

endmodule

// File: rtl/core/idrq_ram.sv
module idrq_ram (
  input  logic            clk,
  input  logic            we,
  input  idrq_pkg::addr_t waddr,
  input  idrq_pkg::elem_t wdata,
  input  logic            re,
  input  idrq_pkg::addr_t raddr_a,
  input  idrq_pkg::addr_t raddr_b,
  output idrq_pkg::elem_t rdata_a,
  output idrq_pkg::elem_t rdata_b
);
  import idrq_pkg::*;

  elem_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: rtl/core/idrq_ctrl.sv
module idrq_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic [idrq_pkg::CMD_W-1:0]      cmd,
  input  idrq_pkg::val_t                  push_value,
  output logic                            ram_we,
  output idrq_pkg::addr_t                 ram_waddr,
  output idrq_pkg::elem_t                 ram_wdata,
  output idrq_pkg::addr_t                 raddr_front,
  output idrq_pkg::addr_t                 raddr_back,
  output idrq_pkg::meta_t                 meta_r
);
  import idrq_pkg::*;

  localparam count_t DEPTH_CNT = count_t'(DEPTH);

  addr_t   head_r, head_nxt;
  count_t  count_r, count_nxt;
  status_t status;
  logic    push_ok;
  meta_t   meta_nxt;

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    status    = ST_OK;
    push_ok   = 1'b0;
    case (cmd)
      CMD_PUSH: begin
        if (count_r >= DEPTH_CNT) begin
          status = ST_OVERFLOW;
        end else begin
          push_ok   = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (count_r == '0) begin
          status = ST_UNDERFLOW;
        end else begin
          head_nxt  = wrap_addr(addr_sum_t'(head_r) + 1'b1);
          count_nxt = count_r - 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (count_r == '0) begin
          status = ST_UNDERFLOW;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      CMD_CLEAR: begin
        head_nxt  = '0;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  assign ram_we      = accept && push_ok;
  assign ram_waddr   = wrap_addr(addr_sum_t'(head_r) + addr_sum_t'(count_r));
  assign ram_wdata   = to_elem(push_value);
  assign raddr_front = head_nxt;
  assign raddr_back  = (count_nxt == '0) ? head_nxt :
                       wrap_addr(addr_sum_t'(head_nxt) + addr_sum_t'(count_nxt - 1'b1));

  always_comb begin
    meta_nxt.count     = count_nxt;
    meta_nxt.status    = status;
    meta_nxt.fwd_back  = push_ok;
    meta_nxt.fwd_front = push_ok && (count_nxt == count_t'(1));
    meta_nxt.push_elem = ram_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (accept) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      meta_r <= meta_nxt;
    end
  end

endmodule
